/* rtl/core/tccw_pkg.sv */
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared constants, codes and types of the text console character writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = COLS * ROWS;

    localparam int IDX_W      = $clog2(CELLS);
    localparam int CUR_COL_W  = $clog2(COLS);
    localparam int CUR_ROW_W  = $clog2(ROWS + 2);
    localparam int TAB_STEP_W = $clog2(TAB_STOP + 1);

    localparam int FUNC_W   = 3;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int CELL_W   = 16;
    localparam int ATTR_PAD = CELL_W - COLOR_W - CHAR_W;

    localparam int FUNC_LSB   = 0;
    localparam int CHAR_LSB   = FUNC_LSB + FUNC_W;
    localparam int COLOR_LSB  = CHAR_LSB + CHAR_W;
    localparam int COLUMN_LSB = COLOR_LSB + COLOR_W;
    localparam int ROW_LSB    = COLUMN_LSB + COL_W;
    localparam int S_TDATA_W  = 32;

    localparam int POS_W      = 11;
    localparam int POS_LSB    = 0;
    localparam int CELL_LSB   = POS_LSB + POS_W;
    localparam int SCR_LSB    = CELL_LSB + CELL_W;
    localparam int M_USED_W   = SCR_LSB + 1;
    localparam int M_TDATA_W  = 32;

    localparam logic [CELL_W-1:0]  BLANK_CELL    = 16'h0720;
    localparam logic [CELL_W-1:0]  SCROLL_FILL   = 16'h0700;
    localparam logic [COLOR_W-1:0] DEFAULT_COLOR = 4'h7;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE_CHAR = 3'd0,
        FUNC_SET_COLOR  = 3'd1,
        FUNC_SET_CURSOR = 3'd2,
        FUNC_READ_CELL  = 3'd3,
        FUNC_CLEAR      = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

endpackage

`default_nettype wire

/* rtl/core/tccw_screen_ram.sv */
// ----------------------------------------------------------------------------
// tccw_screen_ram
// Character cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_screen_ram (
    input  wire logic                          aclk,
    input  wire tccw_pkg::mem_req_t            mem_req,
    output logic [tccw_pkg::CELL_W-1:0]        mem_rdata
);
    import tccw_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];

    always_ff @(posedge aclk) begin
        if (mem_req.we) begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_req.re) begin
            mem_rdata <= mem[mem_req.raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tccw_ctrl.sv */
// ----------------------------------------------------------------------------
// tccw_ctrl
// Cursor, color and sequencer: decodes items, runs the clear, scroll-copy
// and fill sweeps over the cell store, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_ctrl (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [tccw_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [tccw_pkg::M_TDATA_W-1:0]       m_tdata,
    output tccw_pkg::mem_req_t                   mem_req,
    input  wire logic [tccw_pkg::CELL_W-1:0]     mem_rdata
);
    import tccw_pkg::*;

    localparam int SUM_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CELLS - 1);
    localparam logic [IDX_W-1:0] COPY_END  = IDX_W'(CELLS - COLS);

    state_t state_reg, state_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CUR_COL_W-1:0] col_reg, col_next;
    logic [CUR_ROW_W-1:0] row_reg, row_next;
    logic [COLOR_W-1:0]   color_reg, color_next;
    logic                 scr_reg, scr_next;
    logic [CELL_W-1:0]    cell_reg, cell_next;
    logic                 cp_pend_reg, cp_pend_next;
    logic [IDX_W-1:0]     cp_addr_reg, cp_addr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     out_pos_reg, out_pos_next;
    logic [CELL_W-1:0]    out_cell_reg, out_cell_next;
    logic                 out_scr_reg, out_scr_next;

    func_t              in_func;
    logic [CHAR_W-1:0]  in_char;
    logic [COLOR_W-1:0] in_color;
    logic [COL_W-1:0]   in_column;
    logic [ROW_W-1:0]   in_row;
    logic               in_xfer;
    logic               out_free;

    logic [CUR_COL_W-1:0] sel_col;
    logic [CUR_ROW_W-1:0] sel_row;
    logic [IDX_W-1:0]     sel_idx;

    logic [SUM_W-1:0]       ch_idx;
    logic [CUR_COL_W:0]     ch_col;
    logic [CUR_COL_W:0]     col_sum;
    logic [CUR_ROW_W-1:0]   ch_row;
    logic [COLOR_W-1:0]     ch_color;
    logic [TAB_STEP_W-1:0]  tab_step;
    logic                   ch_we;
    logic [IDX_W-1:0]       ch_waddr;
    logic [CELL_W-1:0]      ch_wdata;
    logic                   ch_scroll;
    logic [SUM_W-1:0]       up_idx;
    logic [CUR_ROW_W-1:0]   up_row;
    logic [IDX_W-1:0]       fin_idx;
    logic [CUR_COL_W-1:0]   fin_col;
    logic [CUR_ROW_W-1:0]   fin_row;

    assign in_func   = func_t'(s_tdata[FUNC_LSB +: FUNC_W]);
    assign in_char   = s_tdata[CHAR_LSB +: CHAR_W];
    assign in_color  = s_tdata[COLOR_LSB +: COLOR_W];
    assign in_column = s_tdata[COLUMN_LSB +: COL_W];
    assign in_row    = s_tdata[ROW_LSB +: ROW_W];
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - M_USED_W)'(0), out_scr_reg, out_cell_reg,
                       POS_W'(out_pos_reg)};

    // saturate placement to the screen
    always_comb begin
        sel_col = (int'(in_column) >= COLS) ? CUR_COL_W'(COLS - 1) : CUR_COL_W'(in_column);
        sel_row = (int'(in_row) >= ROWS) ? CUR_ROW_W'(ROWS - 1) : CUR_ROW_W'(in_row);
        sel_idx = IDX_W'(int'(sel_row) * COLS + int'(sel_col));
    end

    always_comb begin
        ch_idx   = SUM_W'(idx_reg);
        ch_col   = {1'b0, col_reg};
        ch_row   = row_reg;
        ch_color = color_reg;
        ch_we    = 1'b0;
        ch_waddr = idx_reg;
        ch_wdata = {{ATTR_PAD{1'b0}}, color_reg, in_char};
        tab_step = TAB_STEP_W'(TAB_STOP - int'(idx_reg % TAB_STOP));
        col_sum  = {1'b0, col_reg} + (CUR_COL_W + 1)'(1);
        case (in_char)
            CH_BACKSPACE: begin
                ch_we    = 1'b1;
                ch_wdata = {{ATTR_PAD{1'b0}}, color_reg, CHAR_W'(0)};
                if (idx_reg != '0) begin
                    ch_idx   = SUM_W'(idx_reg) - SUM_W'(1);
                    ch_waddr = idx_reg - IDX_W'(1);
                    if (col_reg == '0) begin
                        ch_col = (CUR_COL_W + 1)'(COLS - 1);
                        ch_row = row_reg - CUR_ROW_W'(1);
                    end else begin
                        ch_col = {1'b0, col_reg} - (CUR_COL_W + 1)'(1);
                    end
                end
            end
            CH_NEWLINE: begin
                ch_idx   = SUM_W'(idx_reg) - SUM_W'(col_reg) + SUM_W'(COLS);
                ch_col   = '0;
                ch_row   = row_reg + CUR_ROW_W'(1);
                ch_color = DEFAULT_COLOR;
            end
            CH_RETURN: begin
                ch_idx = SUM_W'(idx_reg) - SUM_W'(col_reg);
                ch_col = '0;
            end
            CH_TAB: begin
                col_sum = {1'b0, col_reg} + (CUR_COL_W + 1)'(tab_step);
                ch_idx  = SUM_W'(idx_reg) + SUM_W'(tab_step);
                if (int'(col_sum) >= COLS) begin
                    ch_col = col_sum - (CUR_COL_W + 1)'(COLS);
                    ch_row = row_reg + CUR_ROW_W'(1);
                end else begin
                    ch_col = col_sum;
                end
            end
            default: begin
                ch_we  = 1'b1;
                ch_idx = SUM_W'(idx_reg) + SUM_W'(1);
                if (int'(col_sum) >= COLS) begin
                    ch_col = '0;
                    ch_row = row_reg + CUR_ROW_W'(1);
                end else begin
                    ch_col = col_sum;
                end
            end
        endcase

        ch_scroll = (int'(ch_row) >= ROWS);
        up_idx    = ch_idx - SUM_W'(COLS);
        up_row    = ch_row - CUR_ROW_W'(1);
        fin_idx   = IDX_W'(ch_idx);
        fin_col   = CUR_COL_W'(ch_col);
        fin_row   = ch_row;
        if (ch_scroll) begin
            if (int'(up_row) >= ROWS) begin
                fin_idx = LAST_CELL;
                fin_col = CUR_COL_W'(COLS - 1);
                fin_row = CUR_ROW_W'(ROWS - 1);
            end else begin
                fin_idx = IDX_W'(up_idx);
                fin_row = up_row;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (ptr_reg == LAST_CELL) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    case (in_func)
                        FUNC_WRITE_CHAR: state_next = ch_scroll ? ST_SCROLL : ST_DONE;
                        FUNC_READ_CELL:  state_next = ST_READ;
                        FUNC_CLEAR:      state_next = ST_CLEAR;
                        default:         state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_DONE;
            end
            ST_SCROLL: begin
                if (ptr_reg == COPY_END) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                if (ptr_reg == LAST_CELL) begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR: begin
                if (ptr_reg == LAST_CELL) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = ptr_reg;
        mem_req.wdata = BLANK_CELL;
        mem_req.re    = 1'b0;
        mem_req.raddr = sel_idx;
        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                mem_req.we = 1'b1;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (in_func)
                        FUNC_WRITE_CHAR: begin
                            mem_req.we    = ch_we;
                            mem_req.waddr = ch_waddr;
                            mem_req.wdata = ch_wdata;
                        end
                        FUNC_READ_CELL: begin
                            mem_req.re = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCROLL: begin
                mem_req.we    = cp_pend_reg;
                mem_req.waddr = cp_addr_reg;
                mem_req.wdata = mem_rdata;
                mem_req.re    = (ptr_reg != COPY_END);
                mem_req.raddr = ptr_reg + IDX_W'(COLS);
            end
            ST_FILL: begin
                mem_req.we    = 1'b1;
                mem_req.wdata = SCROLL_FILL;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        color_next     = color_reg;
        scr_next       = scr_reg;
        cell_next      = cell_reg;
        cp_pend_next   = 1'b0;
        cp_addr_next   = ptr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_pos_next   = out_pos_reg;
        out_cell_next  = out_cell_reg;
        out_scr_next   = out_scr_reg;
        case (state_reg)
            ST_INIT, ST_CLEAR, ST_FILL: begin
                ptr_next = ptr_reg + IDX_W'(1);
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    scr_next  = 1'b0;
                    cell_next = '0;
                    ptr_next  = '0;
                    case (in_func)
                        FUNC_WRITE_CHAR: begin
                            idx_next   = fin_idx;
                            col_next   = fin_col;
                            row_next   = fin_row;
                            color_next = ch_color;
                            scr_next   = ch_scroll;
                        end
                        FUNC_SET_COLOR: begin
                            color_next = in_color;
                        end
                        FUNC_SET_CURSOR: begin
                            idx_next = sel_idx;
                            col_next = sel_col;
                            row_next = sel_row;
                        end
                        FUNC_CLEAR: begin
                            idx_next   = '0;
                            col_next   = '0;
                            row_next   = '0;
                            color_next = DEFAULT_COLOR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                cell_next = mem_rdata;
            end
            ST_SCROLL: begin
                if (ptr_reg != COPY_END) begin
                    ptr_next     = ptr_reg + IDX_W'(1);
                    cp_pend_next = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_pos_next   = idx_reg;
                    out_cell_next  = cell_reg;
                    out_scr_next   = scr_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            ptr_reg       <= '0;
            idx_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            color_reg     <= DEFAULT_COLOR;
            cp_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            idx_reg       <= idx_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            color_reg     <= color_next;
            cp_pend_reg   <= cp_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scr_reg      <= scr_next;
        cell_reg     <= cell_next;
        cp_addr_reg  <= cp_addr_next;
        out_pos_reg  <= out_pos_next;
        out_cell_reg <= out_cell_next;
        out_scr_reg  <= out_scr_next;
    end

endmodule

`default_nettype wire

/* rtl/core/text_console_char_writer.sv */
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text-mode console writer: character cell store with cursor, color, control
// codes, scroll, cursor placement, cell read and screen clear.
// ----------------------------------------------------------------------------
//  channel | dir | ports                       | contents
//  s_      | in  | s_tvalid s_tready s_tdata   | func char_code color column row
//  m_      | out | m_tvalid m_tready m_tdata   | cursor_pos cell_value scrolled
//
//  Write char, set color, set cursor: idle then done state; read cell: idle, read, done.
//  Scroll: each cell below the top row is copied one row up, then the bottom row is filled.
//  Clear screen writes all 2000 cells. Sweeps use the single RAM write port.
//  After reset the store is cleared; s_tready stays low until that sweep ends.
//  A result waits in the output register; the block takes the next transfer
//  meanwhile and stalls only when the next result finds that register full.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // func[2:0], char_code[10:3], color[14:11], column[21:15], row[26:22]
    input  wire logic [tccw_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // cursor_pos[10:0], cell_value[26:11], scrolled[27]
    output logic [tccw_pkg::M_TDATA_W-1:0]       m_tdata
);
    import tccw_pkg::*;

    mem_req_t          mem_req;
    logic [CELL_W-1:0] mem_rdata;

    tccw_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    tccw_screen_ram u_ram (
        .aclk      (aclk),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[POS_LSB +: POS_W] <= POS_W'(CELLS - 1)))
        else $error("cursor position beyond last cell");

    a_scroll_bottom: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[SCR_LSB]) |-> (m_tdata[POS_LSB +: POS_W] >= POS_W'(CELLS - COLS)))
        else $error("scrolled result with cursor above bottom row");

    a_port_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
        else $error("read and write of the same cell in one cycle");

endmodule

`default_nettype wire
